/* sv/ecsf_pkg.sv */
// ----------------------------------------------------------------------------
// ecsf_pkg: shared definitions for the escaped CAN serial framer
// Frame constants, field widths and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ecsf_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int HEADER_BYTES   = 5;
    localparam int FRAME_DEPTH    = HEADER_BYTES + MAX_DATA_BYTES;
    localparam int IDX_W          = $clog2(FRAME_DEPTH);
    localparam int END_W          = $clog2(FRAME_DEPTH + 1);

    localparam int DEV_W  = 6;
    localparam int CLS_W  = 7;
    localparam int NUM_W  = 4;
    localparam int MFG_W  = 8;
    localparam int TYP_W  = 8;
    localparam int LEN_W  = 4;
    localparam int PAY_W  = 8 * MAX_DATA_BYTES;

    localparam int IN_BITS   = DEV_W + CLS_W + NUM_W + MFG_W + TYP_W + LEN_W + PAY_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] ESC_BYTE   = 8'hFE;
    localparam logic [7:0] ESC_FOR_FE = 8'hFD;
    localparam logic [7:0] LEN_OFFSET = 8'd4;

    typedef struct packed {
        logic [DEV_W-1:0] device_number;
        logic [CLS_W-1:0] api_class;
        logic [NUM_W-1:0] api_number;
        logic [MFG_W-1:0] manufacturer;
        logic [TYP_W-1:0] device_type;
        logic [LEN_W-1:0] data_length;
        logic [PAY_W-1:0] payload;
    } t_msg;

    typedef enum logic [2:0] {
        EMIT_NONE     = 3'd0,
        EMIT_START    = 3'd1,
        EMIT_BYTE     = 3'd2,
        EMIT_ESC_LEAD = 3'd3,
        EMIT_ESC_CODE = 3'd4
    } t_emit;

    typedef struct packed {
        logic  load;
        t_emit emit;
        logic  advance;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic special;
        logic fin;
    } t_status;

endpackage

`default_nettype wire

/* sv/ecsf_ctrl.sv */
// ----------------------------------------------------------------------------
// ecsf_ctrl: framer controller
// Holds the link enable and sequences start byte, frame bytes and escapes.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_valid,
    input  wire              i_cfg_data,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  ecsf_pkg::t_status i_status,
    output ecsf_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_DATA  = 4'b0100,
        ST_ESC   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_link_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_link_enabled <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_link_enabled <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.emit    = ecsf_pkg::EMIT_NONE;
        o_cmd.advance = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                // drop the word when the link is closed
                if (i_in_valid && r_link_enabled) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = ecsf_pkg::EMIT_START;
                    n_state    = ST_DATA;
                end
            end
            ST_DATA: begin
                if (i_status.slot_free) begin
                    if (i_status.special) begin
                        o_cmd.emit = ecsf_pkg::EMIT_ESC_LEAD;
                        n_state    = ST_ESC;
                    end else begin
                        o_cmd.emit    = ecsf_pkg::EMIT_BYTE;
                        o_cmd.advance = !i_status.fin;
                        n_state       = i_status.fin ? ST_IDLE : ST_DATA;
                    end
                end
            end
            ST_ESC: begin
                if (i_status.slot_free) begin
                    o_cmd.emit    = ecsf_pkg::EMIT_ESC_CODE;
                    o_cmd.advance = !i_status.fin;
                    n_state       = i_status.fin ? ST_IDLE : ST_DATA;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/ecsf_datapath.sv */
// ----------------------------------------------------------------------------
// ecsf_datapath: framer datapath
// Frame byte store, byte index, escape selection and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsf_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ecsf_pkg::t_msg     i_msg,
    input  ecsf_pkg::t_cmd     i_cmd,
    output ecsf_pkg::t_status  o_status,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last
);

    logic [7:0]                   r_frame [ecsf_pkg::FRAME_DEPTH];
    logic [ecsf_pkg::IDX_W-1:0]   r_idx;
    logic [ecsf_pkg::END_W-1:0]   r_end;
    logic                         r_out_valid;
    logic [7:0]                   r_out_byte;
    logic                         r_out_last;

    logic [ecsf_pkg::LEN_W-1:0]   n_len;
    logic [31:0]                  n_ident;
    logic [7:0]                   cur_byte;
    logic [ecsf_pkg::END_W-1:0]   idx_next;
    logic                         cur_fin;

    always_comb begin
        if (i_msg.data_length > ecsf_pkg::LEN_W'(ecsf_pkg::MAX_DATA_BYTES)) begin
            n_len = ecsf_pkg::LEN_W'(ecsf_pkg::MAX_DATA_BYTES);
        end else begin
            n_len = i_msg.data_length;
        end
        // api class bit 6 and manufacturer bit 0 share identifier bit 16
        n_ident = {26'd0, i_msg.device_number}
                | {22'd0, i_msg.api_number, 6'd0}
                | {15'd0, i_msg.api_class, 10'd0}
                | {8'd0, i_msg.manufacturer, 16'd0}
                | {i_msg.device_type, 24'd0};
    end

    assign cur_byte = r_frame[r_idx];
    assign idx_next = ecsf_pkg::END_W'(r_idx) + ecsf_pkg::END_W'(1);
    assign cur_fin  = (idx_next == r_end);

    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.special   = (cur_byte == ecsf_pkg::START_BYTE)
                             || (cur_byte == ecsf_pkg::ESC_BYTE);
    assign o_status.fin       = cur_fin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame[0] <= 8'(n_len) + ecsf_pkg::LEN_OFFSET;
            for (int k = 0; k < 4; k++) begin
                r_frame[1 + k] <= n_ident[8*k +: 8];
            end
            for (int k = 0; k < ecsf_pkg::MAX_DATA_BYTES; k++) begin
                r_frame[ecsf_pkg::HEADER_BYTES + k] <= i_msg.payload[8*k +: 8];
            end
            r_end <= ecsf_pkg::END_W'(ecsf_pkg::HEADER_BYTES) + ecsf_pkg::END_W'(n_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.advance) begin
                r_idx <= ecsf_pkg::IDX_W'(idx_next);
            end
            if (i_cmd.emit != ecsf_pkg::EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            ecsf_pkg::EMIT_START: begin
                r_out_byte <= ecsf_pkg::START_BYTE;
                r_out_last <= 1'b0;
            end
            ecsf_pkg::EMIT_BYTE: begin
                r_out_byte <= cur_byte;
                r_out_last <= cur_fin;
            end
            ecsf_pkg::EMIT_ESC_LEAD: begin
                r_out_byte <= ecsf_pkg::ESC_BYTE;
                r_out_last <= 1'b0;
            end
            ecsf_pkg::EMIT_ESC_CODE: begin
                r_out_byte <= (cur_byte == ecsf_pkg::START_BYTE) ? ecsf_pkg::ESC_BYTE
                                                                  : ecsf_pkg::ESC_FOR_FE;
                r_out_last <= cur_fin;
            end
            default: begin
                // hold the word
                r_out_byte <= r_out_byte;
                r_out_last <= r_out_last;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

/* sv/escaped_can_serial_framer.sv */
// ----------------------------------------------------------------------------
// escaped_can_serial_framer: CAN message to escaped serial byte stream
// Packs the identifier and streams 0xFF, length, id and payload, escaped.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one CAN message per word (id fields, length, payload).
//   m_axis carries the frame one byte per word; tlast marks the final byte.
//   The cfg channel writes link_enabled; it is always ready and should be
//   written only while no frame is in flight.
//   A message is taken only while the controller is idle. With the link
//   closed it is taken and dropped, and nothing is sent.
//   After acceptance, ST_START loads the start byte once the output is free.
//   Throughput: a frame of N output bytes (6 to 26) holds the input until
//   its last byte is emitted; the limit is the single output byte register,
//   one byte per cycle while m_axis is ready. The next message may be taken
//   while the last byte still waits in the output register.
//   When m_axis stalls, the sequencer holds and the byte on the port stays.
//   Reset clears the state machine, the byte index, the output valid and
//   the link enable; the frame byte store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_can_serial_framer (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire                             i_cfg_data,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // device_number, api_class, api_number, manufacturer, device_type,
    // data_length, payload, zero fill
    input  wire [ecsf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // out_byte
    output logic [7:0]                      m_axis_tdata,
    output logic                            m_axis_tlast
);

    ecsf_pkg::t_msg    msg;
    ecsf_pkg::t_cmd    cmd;
    ecsf_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    assign msg.device_number = s_axis_tdata[5:0];
    assign msg.api_class     = s_axis_tdata[12:6];
    assign msg.api_number    = s_axis_tdata[16:13];
    assign msg.manufacturer  = s_axis_tdata[24:17];
    assign msg.device_type   = s_axis_tdata[32:25];
    assign msg.data_length   = s_axis_tdata[36:33];
    assign msg.payload       = s_axis_tdata[36 + ecsf_pkg::PAY_W:37];

    ecsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ecsf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_msg      (msg),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_byte (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sv/ecsf_checker.sv */
// ----------------------------------------------------------------------------
// ecsf_checker: port-level checks for the escaped CAN serial framer
// Watches the stream and config ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsf_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_cfg_valid,
    input wire                           o_cfg_ready,
    input wire                           i_cfg_data,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire [ecsf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [7:0]                     m_axis_tdata,
    input wire                           m_axis_tlast
);

    logic r_link_enabled;
    logic s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_enabled <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_link_enabled <= i_cfg_data;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_link_enabled |=> !s_axis_tready)
        else $error("input taken while a frame is being sent");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata == ecsf_pkg::START_BYTE) |-> !m_axis_tlast)
        else $error("start byte flagged as last");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped under stall");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed under stall");

endmodule

bind escaped_can_serial_framer ecsf_checker u_ecsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_data   (i_cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

/* dv/escaped_can_serial_framer_checker.sv */
// ----------------------------------------------------------------------------
// escaped_can_serial_framer_checker: frame predictor and byte comparator
// Watches the cfg, s_axis and m_axis channels, builds the escaped byte frame
// for every message taken while the link is open, and compares each output
// word in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_can_serial_framer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    // device_number, api_class, api_number, manufacturer, device_type,
    // data_length, payload, zero fill
    input  logic [ecsf_pkg::IN_DATA_W-1:0] i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    // out_byte
    input  logic [7:0]                    i_out_data,
    input  logic                          i_out_last,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int MAX_REPORTS = 10;

    // message word as laid out on s_axis, lowest field last
    typedef struct packed {
        logic [ecsf_pkg::IN_DATA_W-ecsf_pkg::IN_BITS-1:0] fill;
        logic [ecsf_pkg::PAY_W-1:0]                       payload;
        logic [ecsf_pkg::LEN_W-1:0]                       data_length;
        logic [ecsf_pkg::TYP_W-1:0]                       device_type;
        logic [ecsf_pkg::MFG_W-1:0]                       manufacturer;
        logic [ecsf_pkg::NUM_W-1:0]                       api_number;
        logic [ecsf_pkg::CLS_W-1:0]                       api_class;
        logic [ecsf_pkg::DEV_W-1:0]                       device_number;
    } t_msg_word;

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } t_frame_byte;

    t_frame_byte frame_bytes_due[$];
    logic        link_open;
    int          mismatch_count;

    function automatic t_frame_byte mk_byte(input logic [7:0] value, input logic fin);
        t_frame_byte b;
        b.value = value;
        b.fin   = fin;
        return b;
    endfunction

    task automatic predict_frame(input logic [ecsf_pkg::IN_DATA_W-1:0] word);
        t_msg_word                  m;
        logic [ecsf_pkg::LEN_W-1:0] len;
        logic [31:0]                ident;
        logic [7:0]                 body[$];
        logic [7:0]                 b;
        logic                       fin;
        m = word;
        if (m.data_length > ecsf_pkg::MAX_DATA_BYTES) begin
            len = ecsf_pkg::LEN_W'(ecsf_pkg::MAX_DATA_BYTES);
        end else begin
            len = m.data_length;
        end
        // manufacturer lands on top of api_class bit 6
        ident = '0;
        ident[5:0]   = m.device_number;
        ident[9:6]   = m.api_number;
        ident[16:10] = m.api_class;
        ident[23:16] = ident[23:16] | m.manufacturer;
        ident[31:24] = m.device_type;
        body.push_back({4'b0, len} + ecsf_pkg::LEN_OFFSET);
        for (int i = 0; i < 4; i++) begin
            body.push_back(ident[8*i +: 8]);
        end
        for (int i = 0; i < len; i++) begin
            body.push_back(m.payload[8*i +: 8]);
        end
        frame_bytes_due.push_back(mk_byte(ecsf_pkg::START_BYTE, 1'b0));
        foreach (body[i]) begin
            b   = body[i];
            fin = (i == body.size() - 1);
            if (b == ecsf_pkg::START_BYTE) begin
                frame_bytes_due.push_back(mk_byte(ecsf_pkg::ESC_BYTE, 1'b0));
                frame_bytes_due.push_back(mk_byte(ecsf_pkg::ESC_BYTE, fin));
            end else if (b == ecsf_pkg::ESC_BYTE) begin
                frame_bytes_due.push_back(mk_byte(ecsf_pkg::ESC_BYTE, 1'b0));
                frame_bytes_due.push_back(mk_byte(ecsf_pkg::ESC_FOR_FE, fin));
            end else begin
                frame_bytes_due.push_back(mk_byte(b, fin));
            end
        end
    endtask

    initial begin
        link_open      = 1'b0;
        mismatch_count = 0;
        o_fail_count   = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin
        t_frame_byte due;
        if (!i_rst_n) begin
            link_open = 1'b0;
        end else begin
            // drop messages while the link is closed
            if (i_in_valid && i_in_ready && link_open) begin
                predict_frame(i_in_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                link_open = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: unexpected byte %h last %b", $realtime,
                                 i_out_data, i_out_last);
                    end
                    mismatch_count++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (due.value != i_out_data || due.fin != i_out_last) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("%0t: byte expected %h last %b, got %h last %b",
                                     $realtime, due.value, due.fin, i_out_data,
                                     i_out_last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= frame_bytes_due.size();
    end

endmodule

/* dv/escaped_can_serial_framer_test.sv */
// ----------------------------------------------------------------------------
// escaped_can_serial_framer_test: stimulus and verdict for the serial framer
// Writes the link enable, sends directed and random CAN messages with random
// gaps and output stalls, including a long output hold-off and a full drain,
// and reports the checker's result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_can_serial_framer_test;

    localparam int RANDOM_MSGS   = 330;
    localparam int QUIET_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int IDLE_PCT      = 6;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic                           i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // device_number, api_class, api_number, manufacturer, device_type,
    // data_length, payload, zero fill
    logic [ecsf_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // out_byte
    logic [7:0]                     m_axis_tdata;
    logic                           m_axis_tlast;

    int   fail_count;
    int   pending_bytes;
    int   cycle_count;
    logic tx_steady;
    logic rx_steady;
    logic rx_hold_req;

    escaped_can_serial_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    escaped_can_serial_framer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random stalls, a steady stretch, one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [ecsf_pkg::IN_DATA_W-1:0] pack_msg(
        input logic [ecsf_pkg::DEV_W-1:0] dev, input logic [ecsf_pkg::CLS_W-1:0] cls,
        input logic [ecsf_pkg::NUM_W-1:0] num, input logic [ecsf_pkg::MFG_W-1:0] mfg,
        input logic [ecsf_pkg::TYP_W-1:0] typ, input logic [ecsf_pkg::LEN_W-1:0] len,
        input logic [ecsf_pkg::PAY_W-1:0] pay);
        return {{(ecsf_pkg::IN_DATA_W - ecsf_pkg::IN_BITS){1'b0}},
                pay, len, typ, mfg, num, cls, dev};
    endfunction

    // lean toward the two bytes that need escaping
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return ecsf_pkg::START_BYTE;
        if (pick == 1) return ecsf_pkg::ESC_BYTE;
        return 8'($urandom);
    endfunction

    function automatic logic [ecsf_pkg::PAY_W-1:0] rand_payload();
        logic [ecsf_pkg::PAY_W-1:0] pay;
        for (int i = 0; i < ecsf_pkg::MAX_DATA_BYTES; i++) begin
            pay[8*i +: 8] = rand_byte();
        end
        return pay;
    endfunction

    function automatic logic [ecsf_pkg::IN_DATA_W-1:0] rand_msg(input int len);
        return pack_msg(ecsf_pkg::DEV_W'($urandom), ecsf_pkg::CLS_W'($urandom),
                        ecsf_pkg::NUM_W'($urandom), rand_byte(), rand_byte(),
                        ecsf_pkg::LEN_W'(len), rand_payload());
    endfunction

    function automatic int rand_len();
        if ($urandom_range(0, 99) < 12) begin
            return $urandom_range(ecsf_pkg::MAX_DATA_BYTES + 1, 15);
        end
        return $urandom_range(0, ecsf_pkg::MAX_DATA_BYTES);
    endfunction

    task automatic send_msg(input logic [ecsf_pkg::IN_DATA_W-1:0] word);
        int gap;
        if (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 30);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the input until every predicted byte has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_bytes != 0);
    endtask

    task automatic write_link(input logic enable);
        drain();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= enable;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cycle_count   = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        rx_hold_req   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_link(1'b1);

        // field extremes: all zero, all ones with id and payload escaped
        send_msg(pack_msg('0, '0, '0, '0, '0, '0, '0));
        send_msg(pack_msg('1, '1, '1, 8'hFF, 8'hFF,
                          ecsf_pkg::LEN_W'(ecsf_pkg::MAX_DATA_BYTES), '1));
        // oversized lengths saturate
        send_msg(rand_msg(15));
        send_msg(rand_msg(ecsf_pkg::MAX_DATA_BYTES + 1));
        for (int n = 0; n <= ecsf_pkg::MAX_DATA_BYTES; n++) begin
            send_msg(rand_msg(n));
        end
        // identifier bytes 0, 2 and 3 and the payload made of the escape byte
        send_msg(pack_msg(6'h3E, 7'h3F, 4'h3, 8'hFE, 8'hFE,
                          ecsf_pkg::LEN_W'(ecsf_pkg::MAX_DATA_BYTES),
                          {ecsf_pkg::MAX_DATA_BYTES{ecsf_pkg::ESC_BYTE}}));
        // bytes past the length are ignored
        send_msg(pack_msg(6'h15, 7'h2A, 4'h5, 8'h33, 8'h44, ecsf_pkg::LEN_W'(2),
                          64'hFFFF_FFFF_FFFF_1234));
        // api_class bit 6 and manufacturer bit 0 share identifier bit 16
        send_msg(pack_msg('0, 7'h40, '0, 8'h00, '0, '0, '0));
        send_msg(pack_msg('0, 7'h00, '0, 8'h01, '0, '0, '0));
        send_msg(pack_msg('0, 7'h40, '0, 8'h01, '0, '0, '0));
        // escaped final byte
        send_msg(pack_msg(6'h01, '0, '0, 8'h02, 8'h03, ecsf_pkg::LEN_W'(3),
                          64'h00FF_0102));
        send_msg(pack_msg(6'h01, '0, '0, 8'h02, 8'h03, ecsf_pkg::LEN_W'(1),
                          {56'h0, ecsf_pkg::ESC_BYTE}));
        send_msg(pack_msg(6'h07, '0, '0, 8'h00, 8'hFF, '0, '1));

        // link closed: messages vanish
        write_link(1'b0);
        for (int k = 0; k < 4; k++) begin
            send_msg(rand_msg(rand_len()));
        end
        write_link(1'b1);

        for (int k = 0; k < RANDOM_MSGS; k++) begin
            if (k == 100) begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end else if (k == 180) begin
                tx_steady = 1'b0;
                rx_steady = 1'b0;
            end else if (k == 200) begin
                rx_hold_req = 1'b1;
            end else if (k == 240) begin
                drain();
            end else if (k == 300) begin
                write_link(1'b0);
                for (int d = 0; d < 8; d++) begin
                    send_msg(rand_msg(rand_len()));
                end
                write_link(1'b1);
            end
            send_msg(rand_msg(rand_len()));
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_bytes == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/ecsf_pkg.sv
sv/ecsf_ctrl.sv
sv/ecsf_datapath.sv
sv/escaped_can_serial_framer.sv
sv/ecsf_checker.sv
dv/escaped_can_serial_framer_checker.sv
dv/escaped_can_serial_framer_test.sv
